@@ src/mpcd_pkg.sv @@
// ----------------------------------------------------------------------------
// mpcd_pkg: shared types and codes for the mean-placed circular deque
// Command and status codes, controller states and the control bundles
// between controller and datapath.
// ----------------------------------------------------------------------------
package mpcd_pkg;

	localparam int DATA_W   = 32;
	localparam int STATUS_W = 2;
	localparam int FILL_W   = 5;

	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_REMOVE = 1'b1;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

	typedef enum logic {
		S_IDLE,
		S_FETCH
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic exec;       // perform the accepted item
		logic load_head;  // capture RAM read data as new head word
	} ctl_t;

	// datapath -> controller
	typedef struct packed {
		logic fetch;      // item is a remove that leaves words behind
	} sts_t;

endpackage

@@ src/mpcd_ram.sv @@
// ----------------------------------------------------------------------------
// mpcd_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mpcd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ src/mpcd_ctrl.sv @@
// ----------------------------------------------------------------------------
// mpcd_ctrl: deque controller
// Handshake control, output valid and the head refill wait after a remove.
// ----------------------------------------------------------------------------
module mpcd_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	input  mpcd_pkg::sts_t sts,
	output mpcd_pkg::ctl_t ctl
);

	mpcd_pkg::state_t state_q, state_d;
	logic             out_valid_q;
	logic             exec;

	// outputs
	always_comb begin
		in_ready      = (state_q == mpcd_pkg::S_IDLE) && (!out_valid_q || out_ready);
		exec          = in_valid && in_ready;
		ctl.exec      = exec;
		ctl.load_head = (state_q == mpcd_pkg::S_FETCH);
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mpcd_pkg::S_IDLE: begin
				if (exec && sts.fetch) begin
					state_d = mpcd_pkg::S_FETCH;
				end
			end
			mpcd_pkg::S_FETCH: begin
				state_d = mpcd_pkg::S_IDLE;
			end
			default: begin
				state_d = mpcd_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mpcd_pkg::S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (exec) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

@@ src/mpcd_dp.sv @@
// ----------------------------------------------------------------------------
// mpcd_dp: deque datapath
// Word RAM, head/rear pointers, fill count, cached end words, placement
// compare and the result registers.
// ----------------------------------------------------------------------------
module mpcd_dp #(
	parameter int DEPTH     = 16,
	parameter int WORD_BITS = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  mpcd_pkg::ctl_t                      ctl,
	output mpcd_pkg::sts_t                      sts,
	input  logic                                cmd,
	input  logic signed [mpcd_pkg::DATA_W-1:0]  value,
	output logic signed [mpcd_pkg::DATA_W-1:0]  read_value,
	output logic [mpcd_pkg::STATUS_W-1:0]       status,
	output logic [mpcd_pkg::FILL_W-1:0]         fill
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

	logic [PW-1:0]        head_q, rear_q;
	logic [CW-1:0]        count_q;
	logic [WORD_BITS-1:0] head_val_q, rear_val_q;

	logic signed [mpcd_pkg::DATA_W-1:0]  read_value_q;
	logic [mpcd_pkg::STATUS_W-1:0]       status_q;
	logic [mpcd_pkg::FILL_W-1:0]         fill_q;

	logic signed [63:0]       value_ext;
	logic [WORD_BITS-1:0]     word;
	logic signed [WORD_BITS:0] twice, sum_hr;
	logic signed [63:0]       head_ext;
	logic                     empty, full, to_head;
	logic [PW-1:0]            head_fwd, head_back, rear_back;

	logic                 ram_we, ram_re;
	logic [PW-1:0]        ram_waddr, ram_raddr;
	logic [WORD_BITS-1:0] ram_rdata;

	mpcd_ram #(
		.WIDTH(WORD_BITS),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(word),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_comb begin
		value_ext = 64'(value);
		word      = value_ext[WORD_BITS-1:0];
		head_ext  = 64'($signed(head_val_q));
		empty     = (count_q == '0);
		full      = (count_q == CW'(DEPTH));
		// 2v < head + rear, one bit wider so nothing overflows
		twice     = {word, 1'b0};
		sum_hr    = $signed({head_val_q[WORD_BITS-1], head_val_q})
		          + $signed({rear_val_q[WORD_BITS-1], rear_val_q});
		to_head   = twice < sum_hr;
		head_fwd  = (head_q == LAST) ? '0 : head_q + 1'b1;
		head_back = (head_q == '0) ? LAST : head_q - 1'b1;
		rear_back = (rear_q == '0) ? LAST : rear_q - 1'b1;

		ram_we    = 1'b0;
		ram_waddr = rear_q;
		if (ctl.exec && cmd == mpcd_pkg::CMD_INSERT && !full) begin
			ram_we = 1'b1;
			priority if (empty) begin
				ram_waddr = rear_q;
			end else if (to_head) begin
				ram_waddr = head_fwd;
			end else begin
				ram_waddr = rear_back;
			end
		end

		sts.fetch = (cmd == mpcd_pkg::CMD_REMOVE) && (count_q > CW'(1));
		ram_re    = ctl.exec && sts.fetch;
		ram_raddr = head_back;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			rear_q  <= '0;
			count_q <= '0;
		end else if (ctl.exec) begin
			if (cmd == mpcd_pkg::CMD_INSERT) begin
				if (!full) begin
					count_q <= count_q + 1'b1;
					priority if (empty) begin
						head_q <= rear_q;
					end else if (to_head) begin
						head_q <= head_fwd;
					end else begin
						rear_q <= rear_back;
					end
				end
			end else if (!empty) begin
				count_q <= count_q - 1'b1;
				head_q  <= head_back;
			end
		end
	end

	// cached end words and result registers
	always_ff @(posedge clk) begin
		if (ctl.load_head) begin
			head_val_q <= ram_rdata;
		end
		if (ctl.exec) begin
			read_value_q <= '0;
			status_q     <= mpcd_pkg::ST_OK;
			if (cmd == mpcd_pkg::CMD_INSERT) begin
				fill_q <= mpcd_pkg::FILL_W'(count_q + CW'(!full));
				priority if (full) begin
					status_q <= mpcd_pkg::ST_FULL;
				end else if (empty) begin
					head_val_q <= word;
					rear_val_q <= word;
				end else if (to_head) begin
					head_val_q <= word;
				end else begin
					rear_val_q <= word;
				end
			end else begin
				fill_q <= mpcd_pkg::FILL_W'(count_q - CW'(!empty));
				if (empty) begin
					status_q <= mpcd_pkg::ST_EMPTY;
				end else begin
					read_value_q <= head_ext[mpcd_pkg::DATA_W-1:0];
				end
			end
		end
	end

	assign read_value = read_value_q;
	assign status     = status_q;
	assign fill       = fill_q;

endmodule

@@ src/mean_placed_circular_deque.sv @@
// ----------------------------------------------------------------------------
// mean_placed_circular_deque: ring deque with mean-based placement
// Inserts go to the head or rear end depending on the end words' mean;
// removes take from the head end.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries cmd and value; each accepted
//   item yields exactly one result item on the output channel
//   (out_valid/out_ready) with read_value, status and fill.
//   The result is registered and shows in the cycle after the item is taken.
//   Inserts and removes that leave no words behind need no head refill.
//   A remove that leaves words behind passes through the S_FETCH state: the
//   new head word comes from the word RAM's single registered read port
//   before the next placement compare can use it.
//   The head and rear words are cached in registers, so the compare needs
//   no RAM read.
//   Reset clears pointers, fill count and output valid; the RAM holds no
//   reset value and no clearing pass is run.
//   A stalled receiver holds the result; outside a head refill, a new item
//   is taken once the output register is empty or drained in the same cycle.
// ----------------------------------------------------------------------------
module mean_placed_circular_deque #(
	parameter int DEPTH     = 16,
	parameter int WORD_BITS = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic                               cmd,
	input  logic signed [mpcd_pkg::DATA_W-1:0] value,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [mpcd_pkg::DATA_W-1:0] read_value,
	output logic [mpcd_pkg::STATUS_W-1:0]      status,
	output logic [mpcd_pkg::FILL_W-1:0]        fill
);

	mpcd_pkg::ctl_t ctl;
	mpcd_pkg::sts_t sts;

	mpcd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.sts      (sts),
		.ctl      (ctl)
	);

	mpcd_dp #(
		.DEPTH    (DEPTH),
		.WORD_BITS(WORD_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.sts       (sts),
		.cmd       (cmd),
		.value     (value),
		.read_value(read_value),
		.status    (status),
		.fill      (fill)
	);

endmodule
